FILE: hdl/sst_pkg.sv
// Shared types and codes for the membership set table.
// Used by sst_cell and membership_set_table; depends on nothing.
`default_nettype none

package sst_pkg;

  localparam int unsigned InDataBits  = 32;
  localparam int unsigned InUserBits  = 2;
  localparam int unsigned OutDataBits = 16;
  localparam int unsigned CountBits   = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } sst_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } sst_state_e;

  // Search token that hops one cell per cycle along the chain.
  typedef struct packed {
    logic live;
    logic hit;
    logic free;
  } sst_wave_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    logic start;
    logic insert;
    logic remove;
  } sst_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/membership_set_table.sv
// Membership set table: a bounded set of distinct values held in a chain of slot cells.
// Each beat inserts, removes or looks up one value and returns one result beat. The value is
// broadcast to all cells, and a search token then walks the chain one cell per cycle, picking
// up whether the value is held and where the lowest free slot is; a commit cycle then writes
// or clears that slot. A new item is accepted only after the previous one has committed,
// which waits on the token's walk through the CAPACITY cells and, when the output stalls,
// on the result register. An insert of a new value into a full table is refused and flagged.
// member_count reports the count modulo 128. Valid marks clear at reset; no clearing pass.
// Depends on sst_pkg and sst_cell.
`default_nettype none

module membership_set_table #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [0] was_present, [7:1] member_count,
                                          // [8] insert_refused, [15:9] zero
);

  localparam int unsigned SB = (VALUE_BITS < sst_pkg::InDataBits) ? VALUE_BITS
                                                                  : sst_pkg::InDataBits;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sst_pkg::sst_state_e state_q, state_d;
  logic                launch_q;
  logic [1:0]          op_q;
  logic [SB-1:0]       val_q;
  logic                hit_q;
  logic                free_q;
  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q;
  logic [15:0]         out_data_q;

  sst_pkg::sst_wave_t  wave [CAPACITY+1];
  sst_pkg::sst_cmd_t   cmd;

  logic                s_acc;
  logic                out_free;
  logic                do_commit;
  logic                is_insert;
  logic                is_remove;
  logic                refused;
  logic [CW+6:0]       cnt_ext;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign wave[0] = '{live: launch_q, hit: 1'b0, free: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sst_cell #(.VB(SB)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .value_i(val_q),
      .cmd_i  (cmd),
      .wave_i (wave[i]),
      .wave_o (wave[i+1])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sst_pkg::ST_IDLE: begin
        if (s_acc) state_d = sst_pkg::ST_SEARCH;
      end
      sst_pkg::ST_SEARCH: begin
        if (wave[CAPACITY].live) state_d = sst_pkg::ST_COMMIT;
      end
      sst_pkg::ST_COMMIT: begin
        if (out_free) state_d = sst_pkg::ST_IDLE;
      end
      default: state_d = sst_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_axis_tready = 1'b0;
    do_commit     = 1'b0;
    unique case (state_q)
      sst_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      sst_pkg::ST_SEARCH: ;
      sst_pkg::ST_COMMIT: do_commit = out_free;
      default: ;
    endcase
  end

  // Operation decode; the meaningless code behaves as a query.
  always_comb begin
    is_insert = 1'b0;
    is_remove = 1'b0;
    case (op_q)
      sst_pkg::OP_INSERT: is_insert = 1'b1;
      sst_pkg::OP_REMOVE: is_remove = 1'b1;
      sst_pkg::OP_QUERY:  ;
      default: ;
    endcase
  end

  assign refused    = is_insert && !hit_q && !free_q;
  assign cmd.start  = s_acc;
  assign cmd.insert = do_commit && is_insert && !hit_q && free_q;
  assign cmd.remove = do_commit && is_remove && hit_q;

  always_comb begin
    count_d = count_q;
    if (cmd.insert) begin
      count_d = count_q + CW'(1);
    end else if (cmd.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  assign cnt_ext = {7'd0, count_d};

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q  <= s_axis_tuser;
      val_q <= s_axis_tdata[SB-1:0];
    end
    if (wave[CAPACITY].live) begin
      hit_q  <= wave[CAPACITY].hit;
      free_q <= wave[CAPACITY].free;
    end
    if (do_commit) begin
      out_data_q <= {7'd0, refused, cnt_ext[6:0], hit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::ST_IDLE;
      launch_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= s_acc;
      count_q  <= count_d;
      if (do_commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The table never holds more values than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("member count exceeds capacity");

  // The search token launched into the chain always reaches its far end.
  a_wave_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> ##CAPACITY wave[CAPACITY].live)
    else $error("search token lost in the chain");

  // A refused insert only happens on a full table and never for a held value.
  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_commit && refused) |-> (!hit_q && count_q == CW'(CAPACITY)))
    else $error("insert refused with free slots");

  // An accepted insert of a new value raises the count by one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not raise the count");

endmodule

`default_nettype wire

FILE: hdl/sst_cell.sv
// One slot of the membership set table: stored value, valid mark and search flags.
// Depends on sst_pkg for the wave and command structs.
`default_nettype none

module sst_cell #(
  parameter int unsigned VB = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [VB-1:0]     value_i,
  input  wire sst_pkg::sst_cmd_t cmd_i,
  input  wire sst_pkg::sst_wave_t wave_i,
  output sst_pkg::sst_wave_t     wave_o
);

  logic [VB-1:0]      val_q;
  logic               valid_q;
  logic               hit_here_q;
  logic               first_free_q;
  sst_pkg::sst_wave_t wave_q;
  logic               match;

  assign match  = valid_q && (val_q == value_i);
  assign wave_o = wave_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && first_free_q) begin
      val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      hit_here_q   <= 1'b0;
      first_free_q <= 1'b0;
      wave_q       <= '0;
    end else begin
      wave_q.live <= wave_i.live;
      wave_q.hit  <= wave_i.hit | match;
      wave_q.free <= wave_i.free | ~valid_q;
      if (cmd_i.start) begin
        hit_here_q   <= 1'b0;
        first_free_q <= 1'b0;
      end else if (wave_i.live) begin
        hit_here_q <= match;
        // Only the lowest free slot claims the insert.
        first_free_q <= ~wave_i.free & ~valid_q;
      end
      if (cmd_i.insert && first_free_q) begin
        valid_q <= 1'b1;
      end else if (cmd_i.remove && hit_here_q) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_membership_set_table.sv
// Self-checking testbench for membership_set_table: streams insert, remove and query beats,
// predicts each result beat from its own copy of the set and compares field by field.
// Depends on sst_pkg and membership_set_table.
`default_nettype none

module tb_membership_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned POOL_SIZE    = 72;
  localparam int unsigned RANDOM_BLOCK = 166;
  localparam int unsigned NUM_BLOCKS   = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } set_req_t;

  typedef struct packed {
    logic       was_present;
    logic [6:0] member_count;
    logic       insert_refused;
  } set_reply_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  set_req_t    pending_reqs[$];
  set_reply_t  expected_replies[$];
  set_req_t    next_req;
  int unsigned total_reqs;
  int unsigned issued_reqs = 0;
  int unsigned replies_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Predicted contents of the set.
  logic [31:0] held_value[CAPACITY];
  logic        held_valid[CAPACITY];
  int unsigned held_count;

  int unsigned op_tally[4];
  int unsigned hit_tally;
  int unsigned refused_tally;
  int unsigned peak_count;

  membership_set_table #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Applies one operation to the predicted set and returns the result it should produce.
  function automatic set_reply_t apply_set_op(logic [1:0] op, logic [31:0] value);
    set_reply_t reply;
    int hit_slot;
    int free_slot;
    hit_slot  = -1;
    free_slot = -1;
    reply.insert_refused = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (held_valid[i] && held_value[i] == value && hit_slot < 0) hit_slot = i;
      if (!held_valid[i] && free_slot < 0) free_slot = i;
    end
    if (op == sst_pkg::OP_INSERT && hit_slot < 0) begin
      if (free_slot >= 0 && held_count < CAPACITY) begin
        held_value[free_slot] = value;
        held_valid[free_slot] = 1'b1;
        held_count++;
      end else begin
        reply.insert_refused = 1'b1;
        refused_tally++;
      end
    end else if (op == sst_pkg::OP_REMOVE && hit_slot >= 0) begin
      held_valid[hit_slot] = 1'b0;
      if (held_count > 0) held_count--;
    end
    // Any other code, the unused one included, leaves the set untouched.
    reply.was_present  = (hit_slot >= 0);
    reply.member_count = held_count[6:0];
    op_tally[op]++;
    if (hit_slot >= 0) hit_tally++;
    if (held_count > peak_count) peak_count = held_count;
    return reply;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] result %0d: %s expected %0d, got %0d", $time, replies_seen, what, want,
               got);
  endtask

  task automatic check_reply(logic [15:0] beat);
    set_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("unexpected result beat, pending count", 0, 1);
    end else begin
      want = expected_replies.pop_front();
      if (beat[0] !== want.was_present)
        report_mismatch("was_present", want.was_present, beat[0]);
      if (beat[7:1] !== want.member_count)
        report_mismatch("member_count", want.member_count, beat[7:1]);
      if (beat[8] !== want.insert_refused)
        report_mismatch("insert_refused", want.insert_refused, beat[8]);
      if (beat[15:9] !== '0)
        report_mismatch("padding bits", 0, beat[15:9]);
    end
    replies_seen++;
  endtask

  // Phase 0 runs flat out; 1 idles the sender, 2 stalls the receiver, 3 does a bit of both.
  function automatic bit hold_off(bit is_sender);
    int unsigned phase;
    phase = (total_reqs == 0) ? 0 : (issued_reqs * 4) / total_reqs;
    case (phase)
      1: return is_sender && $urandom_range(99) < 64;
      2: return !is_sender && $urandom_range(99) < 64;
      3: return $urandom_range(99) < 17;
      default: return 1'b0;
    endcase
  endfunction

  // Input side: predict on each accepted beat, then present the next one unless idling.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_replies.push_back(apply_set_op(s_axis_tuser, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && !hold_off(1'b1)) begin
          next_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_req.value;
          s_axis_tuser  <= next_req.op;
          issued_reqs   <= issued_reqs + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each accepted result beat and stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
      m_axis_tready <= !hold_off(1'b0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_replies.size());
      $display("tb_membership_set_table: FAIL");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] op, logic [31:0] value);
    set_req_t req;
    req.op    = op;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  initial begin
    logic [31:0] value_pool[POOL_SIZE];
    int unsigned cursor;
    logic [1:0]  op;
    logic [31:0] value;

    for (int i = 0; i < CAPACITY; i++) begin
      held_valid[i] = 1'b0;
      held_value[i] = '0;
    end
    held_count    = 0;
    hit_tally     = 0;
    refused_tally = 0;
    peak_count    = 0;
    for (int i = 0; i < 4; i++) op_tally[i] = 0;

    // Directed: value extremes, repeated inserts, absent removes and the unused code.
    add_req(sst_pkg::OP_QUERY, 32'h0000_0000);
    add_req(sst_pkg::OP_INSERT, 32'h0000_0000);
    add_req(sst_pkg::OP_INSERT, 32'hFFFF_FFFF);
    add_req(sst_pkg::OP_INSERT, 32'h0000_0000);
    add_req(sst_pkg::OP_QUERY, 32'h0000_0000);
    add_req(sst_pkg::OP_QUERY, 32'hFFFF_FFFF);
    add_req(sst_pkg::OP_QUERY, 32'h1234_5678);
    add_req(sst_pkg::OP_REMOVE, 32'h1234_5678);
    add_req(OP_UNUSED, 32'h0000_0000);
    add_req(OP_UNUSED, 32'h5555_5555);
    add_req(sst_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    add_req(sst_pkg::OP_QUERY, 32'hFFFF_FFFF);
    add_req(sst_pkg::OP_INSERT, 32'hAAAA_AAAA);
    add_req(sst_pkg::OP_INSERT, 32'h5555_5555);
    add_req(sst_pkg::OP_REMOVE, 32'h0000_0000);
    add_req(sst_pkg::OP_REMOVE, 32'h0000_0000);
    add_req(sst_pkg::OP_INSERT, 32'h8000_0000);
    add_req(sst_pkg::OP_INSERT, 32'h0000_0001);
    add_req(sst_pkg::OP_REMOVE, 32'hAAAA_AAAA);
    add_req(sst_pkg::OP_INSERT, 32'hFFFF_FFFF);
    add_req(sst_pkg::OP_QUERY, 32'h0000_0001);
    add_req(OP_UNUSED, 32'hFFFF_FFFF);

    // The pool is larger than the table, so walking it with inserts fills the table and
    // then hits refusals; walking it with removes drains the table again.
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    cursor = 0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      for (int k = 0; k < RANDOM_BLOCK; k++) begin
        if ($urandom_range(99) < 75) begin
          op    = (b % 2 == 0) ? sst_pkg::OP_INSERT : sst_pkg::OP_REMOVE;
          value = value_pool[cursor];
          if ($urandom_range(9) != 0) cursor = (cursor + 1) % POOL_SIZE;
        end else begin
          op    = 2'($urandom_range(OP_UNUSED));
          value = ($urandom_range(3) == 0) ? $urandom
                                           : value_pool[$urandom_range(POOL_SIZE - 1)];
        end
        add_req(op, value);
      end
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d operations: %0d inserts, %0d removes, %0d queries, %0d unused code.",
             total_reqs, op_tally[sst_pkg::OP_INSERT], op_tally[sst_pkg::OP_REMOVE],
             op_tally[sst_pkg::OP_QUERY], op_tally[OP_UNUSED]);
    $display("Hits %0d, refused inserts %0d, peak count %0d, %0d results checked, %0d errors.",
             hit_tally, refused_tally, peak_count, replies_seen, error_count);
    if (error_count == 0) begin
      $display("tb_membership_set_table: PASS");
    end else begin
      $display("tb_membership_set_table: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hdl/sst_pkg.sv
hdl/sst_cell.sv
hdl/membership_set_table.sv
tb/tb_membership_set_table.sv
